// ----- src/sbb_pkg.sv -----
package sbb_pkg;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  // Row counter runs up to height + 1 while the tail drains.
  localparam int ROW_W = HEIGHT_REG_W + 1;

  localparam int IMAGE_WIDTH_RESET  = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;

  // Output buffer and the credits that guard it.
  localparam int OBUF_DEPTH = 8;
  localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
  localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  typedef enum logic [1:0] {
    DEN_16,
    DEN_12,
    DEN_9
  } den_t;

  // Per-item control that travels with a pixel down the window pipeline.
  typedef struct packed {
    logic vld;       // item writes the line buffer and shifts the window
    logic emit;      // item completes an output pixel
    logic top_en;    // upper row of this column lies inside the image
    logic bot_en;    // lower row of this column lies inside the image
    logic left_en;   // left column of the window lies inside the image
    logic right_en;  // right column of the window lies inside the image
    logic vedge;     // output pixel sits on the top or bottom row
    logic last;      // final output pixel of the frame
  } item_ctl_t;

endpackage

// ----- src/sbb_in_if.sv -----
interface sbb_in_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface

// ----- src/sbb_out_if.sv -----
interface sbb_out_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- src/sbb_ram.sv -----
module sbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/sbb_ctrl.sv -----
module sbb_ctrl import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  sbb_in_if.sink                       in_stream,
  input  logic                         has_room,
  output item_ctl_t                    s0_ctl,
  output logic [$clog2(MAX_WIDTH)-1:0] s0_col,
  output logic [PIXEL_BITS-1:0]        s0_pix
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
  localparam int RST_W = (MAX_WIDTH < IMAGE_WIDTH_RESET) ? MAX_WIDTH : IMAGE_WIDTH_RESET;

  logic [CW-1:0]           w_m1_r, w_m1_nxt;
  logic [HEIGHT_REG_W-1:0] h_r, h_nxt;
  logic [CW-1:0]           col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;

  logic [CMPW-1:0]         wreq, wclamp;
  logic [HEIGHT_REG_W-1:0] hreq;
  logic [ROW_W-1:0]        h_ext, hp1;
  logic                    accept, in_frame, ignore;
  logic                    col0, col1, row_is1, row_is2, row_is_h, row_is_hp1;

  assign in_stream.ready = has_room;
  assign accept          = in_stream.valid && has_room;

  assign h_ext      = {1'b0, h_r};
  assign hp1        = h_ext + ROW_W'(1);
  assign in_frame   = row_r < h_ext;
  assign col0       = col_r == '0;
  assign col1       = col_r == CW'(1);
  assign row_is1    = row_r == ROW_W'(1);
  assign row_is2    = row_r == ROW_W'(2);
  assign row_is_h   = row_r == h_ext;
  assign row_is_hp1 = row_r == hp1;

  // A flush before the frame is complete is dropped; a pixel after it acts as a flush.
  assign ignore = in_stream.opcode && in_frame;

  always_comb begin
    s0_ctl          = '0;
    s0_ctl.vld      = accept && !ignore;
    s0_ctl.emit     = s0_ctl.vld && ((row_r >= ROW_W'(2)) || (row_is1 && !col0));
    s0_ctl.last     = s0_ctl.emit && col0 && row_is_hp1;
    s0_ctl.top_en   = !row_is1;
    s0_ctl.bot_en   = !row_is_h;
    s0_ctl.left_en  = !col1;
    s0_ctl.right_en = !col0;
    // At column zero the finished pixel belongs to the row before the previous one.
    s0_ctl.vedge    = col0 ? (row_is2 || row_is_hp1) : (row_is1 || row_is_h);
  end

  assign s0_col = col_r;
  assign s0_pix = in_frame ? in_stream.pixel_in : '0;

  always_comb begin
    wreq = CMPW'(cfg_data[WIDTH_REG_W-1:0]);
    if (wreq < CMPW'(2)) begin
      wclamp = CMPW'(2);
    end else if (wreq > CMPW'(MAX_WIDTH)) begin
      wclamp = CMPW'(MAX_WIDTH);
    end else begin
      wclamp = wreq;
    end
    hreq = cfg_data[HEIGHT_REG_W-1:0];

    w_m1_nxt = w_m1_r;
    h_nxt    = h_r;
    col_nxt  = col_r;
    row_nxt  = row_r;

    if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH: begin
          w_m1_nxt = CW'(wclamp - CMPW'(1));
        end
        REG_IMAGE_HEIGHT: begin
          h_nxt = (hreq < HEIGHT_REG_W'(2)) ? HEIGHT_REG_W'(2) : hreq;
        end
        default: begin
          w_m1_nxt = w_m1_r;
        end
      endcase
      // Any register write restarts the frame.
      col_nxt = '0;
      row_nxt = '0;
    end else if (s0_ctl.vld) begin
      if (s0_ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == w_m1_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r <= CW'(RST_W - 1);
      h_r    <= HEIGHT_REG_W'(IMAGE_HEIGHT_RESET);
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      w_m1_r <= w_m1_nxt;
      h_r    <= h_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

// ----- src/sbb_window.sv -----
module sbb_window import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  item_ctl_t                    s0_ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] s0_col,
  input  logic [PIXEL_BITS-1:0]        s0_pix,
  output logic                         sum_vld,
  output logic [PIXEL_BITS+3:0]        sum,
  output den_t                         sum_den,
  output logic                         sum_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int VW = PIXEL_BITS + 2;
  localparam int QW = PIXEL_BITS + 4;

  item_ctl_t               s1_ctl_r, s2_ctl_r;
  logic [CW-1:0]           s1_col_r;
  logic [PIXEL_BITS-1:0]   s1_pix_r;
  logic [2*PIXEL_BITS-1:0] rdata, wdata;
  logic [PIXEL_BITS-1:0]   lb0, lb1;
  logic [VW-1:0]           vsum;
  logic [VW-1:0]           vs0_r, vs1_r, vs2_r;
  logic [QW-1:0]           hsum;
  logic                    hedge;

  logic                    sum_vld_r, sum_last_r;
  logic [QW-1:0]           sum_r;
  den_t                    sum_den_r;

  // Each word holds one column: the row above the incoming pixel and the row above that.
  sbb_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_ctl_r.vld),
    .waddr (s1_col_r),
    .wdata (wdata),
    .re    (s0_ctl.vld),
    .raddr (s0_col),
    .rdata (rdata)
  );

  assign lb0   = rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign lb1   = rdata[PIXEL_BITS-1:0];
  assign wdata = {s1_pix_r, lb0};

  assign vsum = (s1_ctl_r.top_en ? VW'(lb1) : VW'(0))
              + (VW'(lb0) << 1)
              + (s1_ctl_r.bot_en ? VW'(s1_pix_r) : VW'(0));

  assign hsum = (s2_ctl_r.left_en ? QW'(vs2_r) : QW'(0))
              + (QW'(vs1_r) << 1)
              + (s2_ctl_r.right_en ? QW'(vs0_r) : QW'(0));

  assign hedge = !(s2_ctl_r.left_en && s2_ctl_r.right_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r   <= '0;
      s2_ctl_r   <= '0;
      sum_vld_r  <= 1'b0;
    end else begin
      s1_ctl_r   <= s0_ctl;
      s2_ctl_r   <= s1_ctl_r;
      sum_vld_r  <= s2_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r <= s0_col;
    s1_pix_r <= s0_pix;
    if (s1_ctl_r.vld) begin
      vs0_r <= vsum;
      vs1_r <= vs0_r;
      vs2_r <= vs1_r;
    end
    sum_r      <= hsum;
    sum_last_r <= s2_ctl_r.last;
    if (hedge && s2_ctl_r.vedge) begin
      sum_den_r <= DEN_9;
    end else if (hedge || s2_ctl_r.vedge) begin
      sum_den_r <= DEN_12;
    end else begin
      sum_den_r <= DEN_16;
    end
  end

  assign sum_vld  = sum_vld_r;
  assign sum      = sum_r;
  assign sum_den  = sum_den_r;
  assign sum_last = sum_last_r;

endmodule

// ----- src/sbb_div.sv -----
module sbb_div import sbb_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  sum_vld,
  input  logic [PIXEL_BITS+3:0] sum,
  input  den_t                  sum_den,
  input  logic                  sum_last,
  output logic                  res_vld,
  output logic [PIXEL_BITS-1:0] res_pix,
  output logic                  res_last
);

  localparam int QW = PIXEL_BITS + 4;
  localparam int PW = 2 * QW + 1;
  // Reciprocals exact for every dividend below 2**QW.
  localparam longint unsigned M3_L = ((64'd1 << (QW + 2)) + 64'd2) / 64'd3;
  localparam longint unsigned M9_L = ((64'd1 << (QW + 4)) + 64'd8) / 64'd9;
  localparam logic [QW:0] M3 = (QW + 1)'(M3_L);
  localparam logic [QW:0] M9 = (QW + 1)'(M9_L);

  logic [QW-1:0] x;
  logic [QW:0]   mult;
  logic [PW-1:0] prod_r, q;
  den_t          den_r;
  logic          vld_r, last_r;

  // Round to nearest, ties up: divide by 16 is a shift, by 12 is a shift and a divide by 3.
  always_comb begin
    case (sum_den)
      DEN_16: begin
        x    = (sum + QW'(8)) >> 4;
        mult = (QW + 1)'(1);
      end
      DEN_12: begin
        x    = (sum + QW'(6)) >> 2;
        mult = M3;
      end
      DEN_9: begin
        x    = sum + QW'(4);
        mult = M9;
      end
      default: begin
        x    = (sum + QW'(8)) >> 4;
        mult = (QW + 1)'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(x) * PW'(mult);
    den_r  <= sum_den;
    last_r <= sum_last;
  end

  always_comb begin
    case (den_r)
      DEN_16:  q = prod_r;
      DEN_12:  q = prod_r >> (QW + 2);
      DEN_9:   q = prod_r >> (QW + 4);
      default: q = prod_r;
    endcase
  end

  assign res_vld  = vld_r;
  assign res_pix  = q[PIXEL_BITS-1:0];
  assign res_last = last_r;

endmodule

// ----- src/sbb_obuf.sv -----
module sbb_obuf import sbb_pkg::*; #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  reserve,
  output logic                  has_room,
  input  logic                  push,
  input  logic [PIXEL_BITS-1:0] push_pix,
  input  logic                  push_last,
  sbb_out_if.source             out_stream
);

  logic [PIXEL_BITS-1:0] pix_q [OBUF_DEPTH];
  logic                  last_q [OBUF_DEPTH];
  logic [OBUF_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [OBUF_CW-1:0]    fill_r, fill_nxt;
  logic [OBUF_CW-1:0]    credit_r, credit_nxt;
  logic                  pop;

  // A slot is claimed when an item that will produce a pixel is taken in,
  // and handed back when that pixel leaves, so the buffer never overflows.
  assign has_room = credit_r != OBUF_CW'(OBUF_DEPTH);
  assign pop      = out_stream.valid && out_stream.ready;

  assign out_stream.valid      = fill_r != '0;
  assign out_stream.pixel_out  = pix_q[rd_ptr_r];
  assign out_stream.frame_last = last_q[rd_ptr_r];

  always_comb begin
    credit_nxt = credit_r;
    if (reserve && !pop) begin
      credit_nxt = credit_r + OBUF_CW'(1);
    end else if (pop && !reserve) begin
      credit_nxt = credit_r - OBUF_CW'(1);
    end
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + OBUF_CW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - OBUF_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      fill_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      credit_r <= credit_nxt;
      fill_r   <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OBUF_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OBUF_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pix_q[wr_ptr_r]  <= push_pix;
      last_q[wr_ptr_r] <= push_last;
    end
  end

endmodule

// ----- src/separable_binomial_3x3_blur.sv -----
// Channel      Direction  Payload                       Transfer
// in_stream    sink       opcode, pixel_in              valid && ready
// out_stream   source     pixel_out, frame_last         valid && ready
// cfg          write      cfg_addr, cfg_data            cfg_we
//
// One item is taken per clock while in_stream.ready is high. out_stream.valid rises once
// the item that completes a window has passed registers s1 and s2, the sum register, the
// divider's product register and the output buffer; in the stream that item is one row
// plus one pixel later than the output pixel. The rate is set by the line-buffer RAM:
// one column read and one write per cycle. Reset clears the counters; the line buffer is
// not cleared, since words a frame has not yet written never reach a sum. in_stream.ready
// drops while eight result pixels are in flight or waiting in the output buffer.
module separable_binomial_3x3_blur import sbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbb_in_if.sink                in_stream,
  sbb_out_if.source             out_stream,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  item_ctl_t             s0_ctl;
  logic [CW-1:0]         s0_col;
  logic [PIXEL_BITS-1:0] s0_pix;
  logic                  has_room;
  logic                  sum_vld, sum_last;
  logic [PIXEL_BITS+3:0] sum;
  den_t                  sum_den;
  logic                  res_vld, res_last;
  logic [PIXEL_BITS-1:0] res_pix;

  sbb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_stream (in_stream),
    .has_room  (has_room),
    .s0_ctl    (s0_ctl),
    .s0_col    (s0_col),
    .s0_pix    (s0_pix)
  );

  sbb_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .s0_ctl   (s0_ctl),
    .s0_col   (s0_col),
    .s0_pix   (s0_pix),
    .sum_vld  (sum_vld),
    .sum      (sum),
    .sum_den  (sum_den),
    .sum_last (sum_last)
  );

  sbb_div #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .sum_vld  (sum_vld),
    .sum      (sum),
    .sum_den  (sum_den),
    .sum_last (sum_last),
    .res_vld  (res_vld),
    .res_pix  (res_pix),
    .res_last (res_last)
  );

  sbb_obuf #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .reserve    (s0_ctl.emit),
    .has_room   (has_room),
    .push       (res_vld),
    .push_pix   (res_pix),
    .push_last  (res_last),
    .out_stream (out_stream)
  );

endmodule

// ----- bench/tb_separable_binomial_3x3_blur.sv -----
module tb_separable_binomial_3x3_blur import sbb_pkg::*;;

  localparam int MAX_W         = 1024;
  localparam int PIX_W         = 16;
  localparam int RING_DEPTH    = 2 * MAX_W + 2;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RAND_ITEMS    = 250;
  localparam int DIR_N         = 23;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } blur_px_t;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pix;
    logic             typed;
    logic [PIX_W-1:0] want_pix;
    logic             want_last;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  sbb_in_if  #(.PIXEL_BITS(PIX_W)) in_ch ();
  sbb_out_if #(.PIXEL_BITS(PIX_W)) out_ch ();

  separable_binomial_3x3_blur #(
    .MAX_WIDTH (MAX_W),
    .PIXEL_BITS(PIX_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_ch),
    .out_stream(out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // Predictor state: geometry, pixel ring and frame position.
  longint unsigned  geom_w;
  longint unsigned  geom_h;
  logic [PIX_W-1:0] px_ring [RING_DEPTH];
  longint unsigned  next_col;
  longint unsigned  next_row;
  longint unsigned  out_idx;

  blur_px_t blur_expected [$];
  bit       steady;
  int       errors;
  int       taken_items;
  int       results_seen;
  int       frames_done;
  int       cfg_writes;
  int       cycle_cnt;

  stim_row_t dir_rows [DIR_N] = '{
    '{OP_FLUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{OP_PIXEL, 16'h1234, 1'b1, 16'hFFFF, 1'b0},
    '{OP_FLUSH, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{OP_FLUSH, 16'h0000, 1'b1, 16'hFFFF, 1'b1},
    '{OP_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{OP_FLUSH, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{OP_FLUSH, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{OP_FLUSH, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{OP_PIXEL, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{OP_FLUSH, 16'hABCD, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{OP_PIXEL, 16'h7FFE, 1'b0, 16'h0000, 1'b0},
    '{OP_FLUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_FLUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_FLUSH, 16'h0000, 1'b0, 16'h0000, 1'b0}
  };

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tap weight along one direction: the tap outside the image is dropped.
  function automatic longint unsigned edge_weight(int tap, longint unsigned pos,
                                                  longint unsigned n);
    if (tap == 0) return (pos == 0) ? 0 : 1;
    if (tap == 2) return (pos == n - 1) ? 0 : 1;
    return 2;
  endfunction

  function automatic logic [PIX_W-1:0] blur_at(longint unsigned r, longint unsigned c);
    longint unsigned acc;
    longint unsigned den;
    longint unsigned wv;
    longint unsigned wh;
    longint unsigned pos;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      wv = edge_weight(i, r, geom_h);
      if (wv == 0) continue;
      for (int j = 0; j < 3; j++) begin
        wh = edge_weight(j, c, geom_w);
        if (wh == 0) continue;
        pos = (r + i - 1) * geom_w + (c + j - 1);
        acc += wv * wh * px_ring[pos % RING_DEPTH];
      end
    end
    den = (edge_weight(0, r, geom_h) + 2 + edge_weight(2, r, geom_h)) *
          (edge_weight(0, c, geom_w) + 2 + edge_weight(2, c, geom_w));
    return PIX_W'((2 * acc + den) / (2 * den));
  endfunction

  function automatic void restart_frame();
    next_col = 0;
    next_row = 0;
    out_idx  = 0;
  endfunction

  function automatic void blur_config(logic [CFG_ADDR_W-1:0] addr,
                                      logic [CFG_DATA_W-1:0] data);
    longint unsigned v;
    if (addr == REG_IMAGE_WIDTH) begin
      v = data[WIDTH_REG_W-1:0];
      if (v < 2) v = 2;
      if (v > MAX_W) v = MAX_W;
      geom_w = v;
    end else begin
      v = data;
      if (v < 2) v = 2;
      geom_h = v;
    end
    restart_frame();
  endfunction

  // Advances the predictor by one accepted item; returns 1 when it yields a pixel.
  function automatic bit blur_step(input logic op, input logic [PIX_W-1:0] pix,
                                   output blur_px_t res);
    longint unsigned total;
    longint unsigned p;
    total = geom_w * geom_h;
    p     = next_row * geom_w + next_col;
    res   = '0;
    if (p < total && op == OP_FLUSH) return 0;
    taken_items++;
    px_ring[p % RING_DEPTH] = (p < total) ? pix : '0;
    next_col++;
    if (next_col >= geom_w) begin
      next_col = 0;
      next_row++;
    end
    if (p < geom_w + 1) return 0;
    res.pixel = blur_at(out_idx / geom_w, out_idx % geom_w);
    res.last  = (out_idx + 1 >= total);
    if (res.last) restart_frame();
    else out_idx++;
    return 1;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(0, 3));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [PIX_W-1:0] pix,
                           input bit typed = 1'b0, input blur_px_t typed_px = '0);
    int       gap;
    blur_px_t res;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.pixel_in <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (blur_step(op, pix, res)) blur_expected = {blur_expected, (typed ? typed_px : res)};
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (blur_expected.size() != 0) @(posedge clk);
  endtask

  // An ignored flush leaves nothing to wait for, so give the pipeline time to empty.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    blur_config(addr, data);
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w_cfg,
                           input logic [CFG_DATA_W-1:0] h_cfg);
    if ($urandom_range(0, 1)) begin
      cfg_write(REG_IMAGE_WIDTH, w_cfg);
      cfg_write(REG_IMAGE_HEIGHT, h_cfg);
    end else begin
      cfg_write(REG_IMAGE_HEIGHT, h_cfg);
      cfg_write(REG_IMAGE_WIDTH, w_cfg);
    end
  endtask

  // Pixels with a stray flush now and then; those flushes are ignored mid-frame.
  task automatic send_pixels(input longint unsigned n);
    for (longint unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) send_item(OP_FLUSH, PIX_W'($urandom));
      send_item(OP_PIXEL, pick_pixel());
      if ($urandom_range(0, 299) == 0) wait_drained();
    end
  endtask

  task automatic send_frames(input int frames);
    for (int f = 0; f < frames; f++) begin
      send_pixels(geom_w * geom_h);
      // Drain items; a pixel here counts as a flush.
      for (longint unsigned k = 0; k <= geom_w; k++)
        send_item(($urandom_range(0, 5) == 0) ? OP_PIXEL : OP_FLUSH, PIX_W'($urandom));
    end
  endtask

  initial begin : result_side
    int       stall;
    blur_px_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      results_seen++;
      if (blur_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, pixel_out=%h frame_last=%b", $time,
                 out_ch.pixel_out, out_ch.frame_last);
      end else begin
        want = blur_expected.pop_front();
        if (out_ch.pixel_out !== want.pixel) begin
          errors++;
          $display("%0t: pixel_out expected %h actual %h", $time, want.pixel,
                   out_ch.pixel_out);
        end
        if (out_ch.frame_last !== want.last) begin
          errors++;
          $display("%0t: frame_last expected %b actual %b", $time, want.last,
                   out_ch.frame_last);
        end
        if (want.last) frames_done++;
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_separable_binomial_3x3_blur failed");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] w_cfg;
    logic [CFG_DATA_W-1:0] h_cfg;
    int                    base;
    int                    sel;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_PIXEL;
    in_ch.pixel_in <= '0;
    cfg_we         <= 1'b0;
    cfg_addr       <= REG_IMAGE_WIDTH;
    cfg_data       <= '0;
    steady         = 1'b0;
    geom_w         = IMAGE_WIDTH_RESET;
    geom_h         = IMAGE_HEIGHT_RESET;
    restart_frame();
    for (int i = 0; i < RING_DEPTH; i++) px_ring[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Under the reset geometry a frame gives no output this early.
    repeat (5) send_item(OP_PIXEL, PIX_W'($urandom));
    settle();

    // Both registers below their floor, so the image is 2x2.
    configure(16'd1, 16'd0);
    for (int i = 0; i < DIR_N; i++)
      send_item(dir_rows[i].op, dir_rows[i].pix, dir_rows[i].typed,
                blur_px_t'{dir_rows[i].want_pix, dir_rows[i].want_last});
    settle();

    // Width bits above the register are dropped, leaving zero and then the floor.
    steady = 1'b1;
    configure(16'h0800, 16'd1);
    send_frames(2);
    settle();

    // Widest image, clamped from the largest register value; the first outputs
    // only appear once the second row begins, so they show the column wrap.
    steady = 1'b0;
    configure(16'hFFFF, 16'd2);
    send_pixels(MAX_W + 16);
    settle();

    // Tallest image: a long partial frame, cut off by the next configuration.
    configure(16'd2, 16'hFFFF);
    send_pixels(100);
    wait_drained();
    send_pixels(50);
    settle();

    base = taken_items;
    while (taken_items - base < RAND_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) w_cfg = CFG_DATA_W'($urandom_range(0, 1));
      else if (sel < 5) w_cfg = CFG_DATA_W'($urandom_range(10, 40));
      else w_cfg = CFG_DATA_W'($urandom_range(2, 9));
      if ($urandom_range(0, 9) == 0) h_cfg = CFG_DATA_W'($urandom_range(0, 1));
      else h_cfg = CFG_DATA_W'($urandom_range(2, 6));
      steady = ($urandom_range(0, 3) == 0);
      configure(w_cfg, h_cfg);
      send_frames($urandom_range(1, 3));
      if ($urandom_range(0, 2) == 0)
        send_pixels($urandom_range(0, 32'(geom_w * geom_h - 1)));
      settle();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (blur_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d expected pixels never arrived", $time, blur_expected.size());
    end
    $display("Sent %0d stream items and checked %0d blurred pixels over %0d frames,",
             taken_items, results_seen, frames_done);
    $display("with %0d register writes including clamped and masked geometry.", cfg_writes);
    if (errors == 0) begin
      $display("tb_separable_binomial_3x3_blur passed");
    end else begin
      $display("tb_separable_binomial_3x3_blur failed");
    end
    $finish;
  end

endmodule
